// File: rtl/mra_pkg.sv
// Shared types, constants and character helpers for the name code encoder.
`default_nettype none

package mra_pkg;

  // Field widths.
  localparam int PointWidth = 21;
  localparam int CharWidth  = 7;
  localparam int LenWidth   = 3;
  localparam int CodeMax    = 6;
  localparam int CodeHalf   = 3;

  // Code point limits and the one special expansion.
  localparam logic [PointWidth-1:0] AsciiLimit = 21'h000080;
  localparam logic [PointWidth-1:0] SharpS     = 21'h0000DF;

  // Upper-case letters used by cleaning and coding.
  localparam logic [CharWidth-1:0] CharA = 7'h41;
  localparam logic [CharWidth-1:0] CharC = 7'h43;
  localparam logic [CharWidth-1:0] CharE = 7'h45;
  localparam logic [CharWidth-1:0] CharI = 7'h49;
  localparam logic [CharWidth-1:0] CharN = 7'h4E;
  localparam logic [CharWidth-1:0] CharO = 7'h4F;
  localparam logic [CharWidth-1:0] CharS = 7'h53;
  localparam logic [CharWidth-1:0] CharU = 7'h55;
  localparam logic [CharWidth-1:0] CharY = 7'h59;
  localparam logic [CharWidth-1:0] CharZ = 7'h5A;

  // Saturation limits of the running counts.
  localparam logic [1:0]          PointSat = 2'd2;
  localparam logic [LenWidth-1:0] KeptSat  = 3'd7;

  // Output of the cleaning step: zero, one or two copies of one character.
  typedef struct packed {
    logic [1:0]           count;
    logic [CharWidth-1:0] ch;
  } clean_t;

  // One item as the update logic sees it.
  typedef struct packed {
    logic   has_char;
    logic   last;
    clean_t clean;
  } step_t;

  // Running state of the word being coded.
  typedef struct packed {
    logic [1:0]                          point_count;
    logic                                any_cleaned;
    logic [CharWidth-1:0]                prev_kept;
    logic                                pair_open;
    logic [LenWidth-1:0]                 kept_count;
    logic [CodeMax-1:0][CharWidth-1:0]   code_store;
  } word_state_t;

  // One finished code; char0 sits in chars[0].
  typedef struct packed {
    logic [CodeMax-1:0][CharWidth-1:0] chars;
    logic [LenWidth-1:0]               code_length;
  } result_t;

  function automatic logic is_vowel(logic [CharWidth-1:0] c);
    return (c == CharA) || (c == CharE) || (c == CharI) || (c == CharO) || (c == CharU);
  endfunction

  function automatic logic is_upper(logic [CharWidth-1:0] c);
    return (c >= CharA) && (c <= CharZ);
  endfunction

  // Accent folding of U+00C0..U+00FF, indexed by the low five bits; zero means no fold.
  function automatic logic [CharWidth-1:0] fold_latin1(logic [4:0] idx);
    logic [CharWidth-1:0] r;
    case (idx) inside
      [5'd0:5'd5]:   r = CharA;
      5'd7:          r = CharC;
      [5'd8:5'd11]:  r = CharE;
      [5'd12:5'd15]: r = CharI;
      5'd17:         r = CharN;
      [5'd18:5'd22]: r = CharO;
      [5'd25:5'd28]: r = CharU;
      5'd29, 5'd31:  r = CharY;
      default:       r = '0;
    endcase
    return r;
  endfunction

  // Apply one cleaned character to the word state.
  function automatic word_state_t take_cleaned(word_state_t st, logic [CharWidth-1:0] c);
    word_state_t r;
    r = st;
    if (!(st.any_cleaned && is_vowel(c))) begin
      r.any_cleaned = 1'b1;
      if (st.pair_open && (st.prev_kept == c) && is_upper(c) && !is_vowel(c)) begin
        // Second half of a double consonant: swallow it and close the pair.
        r.pair_open = 1'b0;
      end else begin
        if (st.kept_count < LenWidth'(CodeMax)) begin
          for (int k = 0; k < CodeMax; k++) begin
            if (st.kept_count == LenWidth'(k)) begin
              r.code_store[k] = c;
            end
          end
        end else begin
          // Past six characters the tail slides to keep the latest three.
          for (int k = CodeHalf; k < CodeMax - 1; k++) begin
            r.code_store[k] = st.code_store[k+1];
          end
          r.code_store[CodeMax-1] = c;
        end
        if (st.kept_count < KeptSat) begin
          r.kept_count = st.kept_count + 1'b1;
        end
        r.prev_kept = c;
        r.pair_open = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mra_clean.sv
// Cleaning of one code point into zero, one or two characters, with letters raised to upper case.
`default_nettype none

module point_cleaner (
  input  wire logic [mra_pkg::PointWidth-1:0] code_point,
  output mra_pkg::clean_t                     clean
);
  import mra_pkg::*;

  logic [CharWidth-1:0] ascii_ch;
  logic [CharWidth-1:0] folded;

  // Accent folding for the Latin ranges that have one.
  always_comb begin
    folded = '0;
    if (code_point[PointWidth-1:6] == 15'h0003) begin
      folded = fold_latin1(code_point[4:0]);
    end else if (code_point[PointWidth-1:1] == 20'h000A8) begin
      folded = CharO;
    end else if (code_point[PointWidth-1:1] == 20'h000B8) begin
      folded = CharU;
    end else if ((code_point >= 21'h000176) && (code_point <= 21'h000178)) begin
      folded = CharY;
    end
  end

  // ASCII is raised to upper case; the listed punctuation and whitespace are dropped.
  always_comb begin
    ascii_ch = code_point[CharWidth-1:0];
    if ((ascii_ch >= 7'h61) && (ascii_ch <= 7'h7A)) begin
      ascii_ch = ascii_ch & ~7'h20;
    end
    clean = '0;
    if (code_point < AsciiLimit) begin
      case (code_point[CharWidth-1:0]) inside
        // Hyphen, ampersand, apostrophe, period, comma, space, TAB..CR.
        7'h2D, 7'h26, 7'h27, 7'h2E, 7'h2C, 7'h20, [7'h09:7'h0D]: clean = '0;
        default: begin
          clean.count = 2'd1;
          clean.ch    = ascii_ch;
        end
      endcase
    end else if (code_point == SharpS) begin
      clean.count = 2'd2;
      clean.ch    = CharS;
    end else if (folded != '0) begin
      clean.count = 2'd1;
      clean.ch    = folded;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mra_core.sv
// Running word state: vowel removal, double collapse and code assembly.
`default_nettype none

module mra_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire mra_pkg::step_t  step,
  output mra_pkg::result_t     result
);
  import mra_pkg::*;

  word_state_t state;
  word_state_t mid;
  word_state_t state_next;
  logic [LenWidth-1:0] len;

  // Apply the item's cleaned characters, one after the other.
  always_comb begin
    mid = state;
    if (step.has_char) begin
      if (state.point_count < PointSat) begin
        mid.point_count = state.point_count + 1'b1;
      end
      if (step.clean.count != 2'd0) begin
        mid = take_cleaned(mid, step.clean.ch);
      end
      if (step.clean.count == 2'd2) begin
        mid = take_cleaned(mid, step.clean.ch);
      end
    end
    state_next = step.last ? '0 : mid;
  end

  // Finished code from the state after this item.
  always_comb begin
    len = (mid.kept_count < LenWidth'(CodeMax)) ? mid.kept_count : LenWidth'(CodeMax);
    if (mid.point_count < PointSat) begin
      len = '0;
    end
    result.code_length = len;
    for (int k = 0; k < CodeMax; k++) begin
      result.chars[k] = (LenWidth'(k) < len) ? mid.code_store[k] : '0;
    end
  end

  // State register, cleared at reset and after every word end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  a_clear_after_word: assert property (@(posedge clk) disable iff (rst)
    advance && step.last |=> (state.kept_count == '0) && (state.point_count == '0))
    else $error("word state not cleared after word end");

  a_pair_needs_char: assert property (@(posedge clk) disable iff (rst)
    state.pair_open |-> (state.kept_count != '0))
    else $error("pair open with no kept character");

  a_kept_needs_clean: assert property (@(posedge clk) disable iff (rst)
    (state.kept_count != '0) |-> state.any_cleaned)
    else $error("kept characters without any cleaned character");

endmodule

`default_nettype wire

// File: rtl/match_rating_encoder.sv
// Top level of the name code encoder: input register, update logic, result register.
//
// Input channel (s_*): one decoded code point per transfer. s_tdata[20:0] is the
// code point, s_tuser says whether the code point is valid (0 for an end-only
// item), and s_tlast marks the last item of a word.
// Output channel (m_*): one transfer per word, issued for each input item with
// s_tlast set. m_tdata carries the code length and the six code characters.
// Throughput: one input item per cycle, sustained, as long as results drain.
// The result of a word is registered in the result register when its last item
// leaves the input register, and the output transfer is made from that register.
// The input register is one item deep; the result register holds one code.
// If the receiver stalls, a finished code stays in the result register; items
// that produce no result keep flowing, and the first end-of-word item then
// waits in the input register, which holds s_tready low.
// Reset clears both registers and the word state; the next word starts empty.
`default_nettype none

module match_rating_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // code_point [20:0], zero fill [23:21]
  input  wire logic        s_tuser,   // has_char [0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // code_length [2:0], char0..char5 [44:3], zero fill
);
  import mra_pkg::*;

  logic                  in_valid;
  logic [PointWidth-1:0] in_cp;
  logic                  in_has;
  logic                  in_last;
  logic                  advance;
  clean_t                clean;
  step_t                 step;
  result_t               result;
  result_t               out_result;

  // An item leaves the input register unless it ends a word and the result slot is busy.
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cp   <= s_tdata[PointWidth-1:0];
      in_has  <= s_tuser;
      in_last <= s_tlast;
    end
  end

  point_cleaner u_clean (
    .code_point (in_cp),
    .clean      (clean)
  );

  assign step = '{has_char: in_has, last: in_last, clean: clean};

  mra_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .step    (step),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {3'b000, out_result};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && in_last && m_tvalid)
    else $error("input stalled without a pending word end");

  a_word_end_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_tvalid)
    else $error("word end produced no result");

  a_empty_code_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == 3'd0) |-> (m_tdata[44:3] == '0))
    else $error("empty code carries characters");

endmodule

`default_nettype wire
